[design/srta_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srta_pkg: shared types and constants for the soil resistance averager
// Sample and result payloads, queue entry, divider request/response and the
// sizes derived from the window length and ADC width.
// ----------------------------------------------------------------------------
package srta_pkg;

	localparam int SAMPLE_BITS      = 10;
	localparam int READS_PER_WINDOW = 11;
	localparam int REF_BITS         = 16;
	localparam int RES_BITS         = 24;
	localparam logic [REF_BITS-1:0] REF_RESET = REF_BITS'(4700);

	// window position counter, running sum and divider sizes
	localparam int CNT_BITS  = $clog2(READS_PER_WINDOW + 1);
	localparam int SUM_BITS  = RES_BITS + $clog2(READS_PER_WINDOW + 1);
	localparam int PROD_BITS = REF_BITS + SAMPLE_BITS;
	localparam int DIV_BITS  = (PROD_BITS > SUM_BITS) ? PROD_BITS : SUM_BITS;
	localparam int DVS_BITS  = (SAMPLE_BITS > CNT_BITS) ? SAMPLE_BITS : CNT_BITS;
	localparam int DCNT_BITS = $clog2(DIV_BITS);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// saturation limits on a quotient magnitude
	localparam logic [DIV_BITS-1:0] RES_POS_LIM = DIV_BITS'((64'd1 << (RES_BITS - 1)) - 64'd1);
	localparam logic [DIV_BITS-1:0] RES_NEG_LIM = DIV_BITS'(64'd1 << (RES_BITS - 1));

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] supply_sample;
		logic [SAMPLE_BITS-1:0] sensor_sample;
	} sample_t;

	typedef struct packed {
		logic signed [RES_BITS-1:0] bias;
		logic signed [RES_BITS-1:0] compensated;
		logic                       zero_divide;
	} result_t;

	// one classified request waiting for the back end
	typedef struct packed {
		logic                zero;
		logic                neg;
		logic [DIV_BITS-1:0] mag;
		logic [DVS_BITS-1:0] dvs;
	} job_t;

	typedef struct packed {
		logic                start;
		logic [DIV_BITS-1:0] dividend;
		logic [DVS_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [DIV_BITS-1:0] quotient;
	} div_rsp_t;

endpackage

[design/srta_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srta_front: request intake and classification
// Holds the reference register, forms |ref*(supply-sensor)|, its sign and the
// divisor, and flags a zero sensor reading.
// ----------------------------------------------------------------------------
module srta_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [srta_pkg::REF_BITS-1:0]     cfg_data,
	input  srta_pkg::sample_t                 sample,
	input  logic                              accept,
	output logic                              push,
	output srta_pkg::job_t                    job
);

	logic [srta_pkg::REF_BITS-1:0]    ref_q;
	logic                             zero;
	logic                             neg;
	logic [srta_pkg::SAMPLE_BITS-1:0] absd;
	logic [srta_pkg::SAMPLE_BITS-1:0] mul_op;
	logic [srta_pkg::PROD_BITS-1:0]   prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= srta_pkg::REF_RESET;
		end else if (cfg_we) begin
			ref_q <= cfg_data;
		end
	end

	always_comb begin
		zero   = (sample.sensor_sample == '0);
		neg    = (sample.supply_sample < sample.sensor_sample);
		absd   = neg ? (sample.sensor_sample - sample.supply_sample)
		             : (sample.supply_sample - sample.sensor_sample);
		// zero sensor: full-scale reading over a divisor of one
		mul_op = zero ? '1 : absd;
		prod   = srta_pkg::PROD_BITS'(ref_q) * srta_pkg::PROD_BITS'(mul_op);
	end

	assign push     = accept;
	assign job.zero = zero;
	assign job.neg  = neg;
	assign job.mag  = srta_pkg::DIV_BITS'(prod);
	assign job.dvs  = zero ? srta_pkg::DVS_BITS'(1)
	                       : srta_pkg::DVS_BITS'(sample.sensor_sample);

endmodule

[design/srta_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srta_queue: short request queue between front and back end
// Small register FIFO; full stalls the front, empty idles the back.
// ----------------------------------------------------------------------------
module srta_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  srta_pkg::job_t wr_job,
	output logic           full,
	input  logic           pop,
	output srta_pkg::job_t rd_job,
	output logic           empty
);

	srta_pkg::job_t                   mem_q [srta_pkg::QUEUE_DEPTH];
	logic [srta_pkg::QPTR_BITS-1:0]   wr_ptr_q;
	logic [srta_pkg::QPTR_BITS-1:0]   rd_ptr_q;
	logic [srta_pkg::QCNT_BITS-1:0]   count_q;

	assign full   = (count_q == srta_pkg::QCNT_BITS'(srta_pkg::QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/srta_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srta_div: iterative unsigned divider
// Restoring radix-2, one quotient bit per cycle, done pulses after the last.
// ----------------------------------------------------------------------------
module srta_div (
	input  logic               clk,
	input  logic               arst_n,
	input  srta_pkg::div_req_t req,
	output srta_pkg::div_rsp_t rsp
);

	logic                              busy_q;
	logic                              done_q;
	logic [srta_pkg::DCNT_BITS-1:0]    cnt_q;
	logic [srta_pkg::DIV_BITS-1:0]     quo_q;
	logic [srta_pkg::DVS_BITS-1:0]     rem_q;
	logic [srta_pkg::DVS_BITS-1:0]     dvs_q;
	logic [srta_pkg::DVS_BITS:0]       shifted;
	logic [srta_pkg::DVS_BITS:0]       diff;
	logic                              ge;

	always_comb begin
		shifted = {rem_q, quo_q[srta_pkg::DIV_BITS-1]};
		diff    = shifted - {1'b0, dvs_q};
		ge      = (shifted >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[srta_pkg::DIV_BITS-2:0], ge};
			rem_q <= ge ? diff[srta_pkg::DVS_BITS-1:0] : shifted[srta_pkg::DVS_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == srta_pkg::DCNT_BITS'(srta_pkg::DIV_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

[design/srta_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srta_back: resistance, window average and two-phase result sequencer
// Drives the shared divider for each resistance and each window average,
// keeps the running sum and the first-phase average, owns the result register.
// ----------------------------------------------------------------------------
module srta_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  srta_pkg::job_t      job,
	output logic                pop,
	output srta_pkg::div_req_t  div_req,
	input  srta_pkg::div_rsp_t  div_rsp,
	output logic                result_valid,
	input  logic                result_stall,
	output srta_pkg::result_t   result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIVR = 3'd1;
	localparam logic [2:0] ST_ACC  = 3'd2;
	localparam logic [2:0] ST_DIVA = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	localparam int RB = srta_pkg::RES_BITS;
	localparam int SB = srta_pkg::SUM_BITS;

	logic [2:0]                       state_q;
	logic                             neg_q;
	logic signed [RB-1:0]             res_q;
	logic signed [SB-1:0]             sum_q;
	logic [srta_pkg::CNT_BITS-1:0]    count_q;
	logic                             second_q;
	logic                             saw_zero_q;
	logic signed [RB-1:0]             first_q;
	logic signed [RB-1:0]             avg_q;
	logic                             out_valid_q;
	srta_pkg::result_t                out_q;

	logic signed [SB-1:0]             sum_next;
	logic [SB-1:0]                    sum_mag;
	logic                             window_end;
	logic [srta_pkg::DIV_BITS-1:0]    q;
	logic signed [RB-1:0]             res_sat;
	logic signed [RB-1:0]             avg_val;
	logic signed [RB:0]               pair_diff;
	logic signed [RB:0]               pair_sum;
	logic signed [RB:0]               pair_adj;
	logic signed [RB-1:0]             bias_sat;
	logic                             out_free;

	always_comb begin
		sum_next   = sum_q + SB'(res_q);
		sum_mag    = sum_next[SB-1] ? (-sum_next) : sum_next;
		window_end = (count_q == srta_pkg::CNT_BITS'(srta_pkg::READS_PER_WINDOW - 1));
		q          = div_rsp.quotient;

		// quotient magnitude back to a saturated signed resistance
		if (!neg_q) begin
			res_sat = (q > srta_pkg::RES_POS_LIM) ? {1'b0, {(RB-1){1'b1}}} : q[RB-1:0];
		end else begin
			res_sat = (q > srta_pkg::RES_NEG_LIM) ? {1'b1, {(RB-1){1'b0}}} : (-q[RB-1:0]);
		end
		avg_val = neg_q ? (-q[RB-1:0]) : q[RB-1:0];

		pair_diff = (RB+1)'(first_q) - (RB+1)'(avg_q);
		pair_sum  = (RB+1)'(first_q) + (RB+1)'(avg_q);
		// halve toward zero: bias negative sums up by one before the shift
		pair_adj  = pair_sum + (RB+1)'(pair_sum[RB]);
		if (pair_diff[RB] != pair_diff[RB-1]) begin
			bias_sat = pair_diff[RB] ? {1'b1, {(RB-1){1'b0}}} : {1'b0, {(RB-1){1'b1}}};
		end else begin
			bias_sat = pair_diff[RB-1:0];
		end

		out_free = !out_valid_q || !result_stall;
		pop      = (state_q == ST_IDLE) && !empty;

		div_req.start    = 1'b0;
		div_req.dividend = job.mag;
		div_req.divisor  = job.dvs;
		if (pop) begin
			div_req.start = 1'b1;
		end else if ((state_q == ST_ACC) && window_end) begin
			div_req.start    = 1'b1;
			div_req.dividend = srta_pkg::DIV_BITS'(sum_mag);
			div_req.divisor  = srta_pkg::DVS_BITS'(srta_pkg::READS_PER_WINDOW);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIVR && div_rsp.done) begin
			res_q <= res_sat;
		end
		if (state_q == ST_DIVA && div_rsp.done) begin
			avg_q <= avg_val;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_q.bias        <= bias_sat;
			out_q.compensated <= pair_adj[RB:1];
			out_q.zero_divide <= saw_zero_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			neg_q       <= 1'b0;
			sum_q       <= '0;
			count_q     <= '0;
			second_q    <= 1'b0;
			saw_zero_q  <= 1'b0;
			first_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// in EMIT the load below takes over the valid bit
			if (out_valid_q && !result_stall && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						neg_q      <= job.neg;
						saw_zero_q <= saw_zero_q | job.zero;
						state_q    <= ST_DIVR;
					end
				end
				ST_DIVR: begin
					if (div_rsp.done) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (window_end) begin
						neg_q   <= sum_next[SB-1];
						sum_q   <= '0;
						count_q <= '0;
						state_q <= ST_DIVA;
					end else begin
						sum_q   <= sum_next;
						count_q <= count_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_DIVA: begin
					if (div_rsp.done) begin
						if (!second_q) begin
							first_q  <= avg_val;
							second_q <= 1'b1;
							state_q  <= ST_IDLE;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						second_q    <= 1'b0;
						saw_zero_q  <= 1'b0;
						first_q     <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

[design/soil_resistance_two_phase_average.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soil_resistance_two_phase_average: polarity-compensated soil resistance
// Turns supply/sensor ADC pairs into resistances, averages each window and
// reports bias and compensated value after every second window.
// ----------------------------------------------------------------------------
// Each request is one ADC pair (supply, sensor). The resistance
// ref*(supply-sensor)/sensor is divided toward zero and saturated to 24 bits
// signed; a zero sensor reading counts as ref*(2^SAMPLE_BITS-1) and sets the
// zero_divide flag of the current pair of windows. READS_PER_WINDOW
// resistances are summed and divided toward zero by the window size. The
// first window's average is held; when the second (reversed polarity) window
// closes, one result comes out: bias = first - second (saturated) and
// compensated = (first + second) / 2 toward zero. All other requests produce
// no result. Throughput is set by the single shared radix-2 divider, which
// retires one quotient bit per cycle over DIV_BITS bits (28 at the default
// sizes); the back end takes one request at a time, and the request closing a
// window runs the divider once more for the average before the result
// register is loaded. A two-entry queue lets the sample side keep feeding
// requests while the back end divides, and the result register lets a new
// request start while an earlier result is still stalled. The reference
// register is written through cfg_we/cfg_data; write it only while no request
// is in flight.
// ----------------------------------------------------------------------------
module soil_resistance_two_phase_average (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: reference_resistance
	input  logic                          cfg_we,
	input  logic [srta_pkg::REF_BITS-1:0] cfg_data,
	// sample request channel
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  srta_pkg::sample_t             sample,
	// result channel
	output logic                          result_valid,
	input  logic                          result_stall,
	output srta_pkg::result_t             result
);

	logic               accept;
	logic               push;
	logic               full;
	logic               empty;
	logic               pop;
	srta_pkg::job_t     wr_job;
	srta_pkg::job_t     rd_job;
	srta_pkg::div_req_t div_req;
	srta_pkg::div_rsp_t div_rsp;

	// the front stalls only when the queue is full
	assign sample_stall = full;
	assign accept       = sample_valid && !full;

	// front: reference register, product and divisor selection
	srta_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.sample   (sample),
		.accept   (accept),
		.push     (push),
		.job      (wr_job)
	);

	// decoupling queue between intake and the divider sequencer
	srta_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.full   (full),
		.pop    (pop),
		.rd_job (rd_job),
		.empty  (empty)
	);

	// shared divider: resistance quotients and window averages
	srta_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// back end: accumulation, phase tracking and result register
	srta_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.job          (rd_job),
		.pop          (pop),
		.div_req      (div_req),
		.div_rsp      (div_rsp),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
